>>> rtl/core/hfr_pkg.sv
// Shared constants, register codes and types of the HDLC-like frame receiver.
package hfr_pkg;

  // Payload limit and field widths.
  localparam int unsigned MAX_PAYLOAD = 1024;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned COUNT_W     = 11;
  localparam int unsigned STATUS_W    = 3;
  localparam int unsigned PHASE_W     = 3;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned OUT_DATA_W  = 40;

  // A data byte arriving at this count overflows the frame.
  localparam logic [COUNT_W-1:0] COUNT_LIMIT = COUNT_W'(MAX_PAYLOAD + 1);

  // Receive phases.
  localparam logic [PHASE_W-1:0] PH_START   = 3'd0;
  localparam logic [PHASE_W-1:0] PH_ADDRESS = 3'd1;
  localparam logic [PHASE_W-1:0] PH_CONTROL = 3'd2;
  localparam logic [PHASE_W-1:0] PH_BCC1    = 3'd3;
  localparam logic [PHASE_W-1:0] PH_DATA    = 3'd4;

  // Status codes reported with each result.
  localparam logic [STATUS_W-1:0] ST_BUSY        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_OK          = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_ADDRESS = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_CONTROL = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BCC2_ERROR  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW    = 3'd5;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_FLAG       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ESCAPE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ESC_MASK   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ADDRESS    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CTRL_ZERO  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CTRL_ONE   = 3'd5;

  // Configuration register reset values.
  localparam logic [BYTE_W-1:0] RST_FLAG      = 8'd126;
  localparam logic [BYTE_W-1:0] RST_ESCAPE    = 8'd125;
  localparam logic [BYTE_W-1:0] RST_ESC_MASK  = 8'd32;
  localparam logic [BYTE_W-1:0] RST_ADDRESS   = 8'd3;
  localparam logic [BYTE_W-1:0] RST_CTRL_ZERO = 8'd0;
  localparam logic [BYTE_W-1:0] RST_CTRL_ONE  = 8'd64;

  // Current register settings.
  typedef struct packed {
    logic [BYTE_W-1:0] flag_byte;
    logic [BYTE_W-1:0] escape_byte;
    logic [BYTE_W-1:0] escape_xor_mask;
    logic [BYTE_W-1:0] address_byte;
    logic [BYTE_W-1:0] control_frame_zero;
    logic [BYTE_W-1:0] control_frame_one;
  } hfr_cfg_t;

  // One result item.
  typedef struct packed {
    logic [COUNT_W-1:0]  frame_length;
    logic [COUNT_W-1:0]  data_index;
    logic [BYTE_W-1:0]   data_byte;
    logic                data_valid;
    logic [STATUS_W-1:0] status;
  } hfr_result_t;

endpackage

>>> rtl/core/hfr_cfg_regs.sv
// Configuration register file of the HDLC-like frame receiver.
module hfr_cfg_regs
  import hfr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [BYTE_W-1:0]    wr_data,
  output hfr_cfg_t             cfg
);

  hfr_cfg_t cfg_r;
  hfr_cfg_t cfg_nxt;

  // Decode the register index; unknown indexes are ignored.
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        REG_FLAG:      cfg_nxt.flag_byte          = wr_data;
        REG_ESCAPE:    cfg_nxt.escape_byte        = wr_data;
        REG_ESC_MASK:  cfg_nxt.escape_xor_mask    = wr_data;
        REG_ADDRESS:   cfg_nxt.address_byte       = wr_data;
        REG_CTRL_ZERO: cfg_nxt.control_frame_zero = wr_data;
        REG_CTRL_ONE:  cfg_nxt.control_frame_one  = wr_data;
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.flag_byte          <= RST_FLAG;
      cfg_r.escape_byte        <= RST_ESCAPE;
      cfg_r.escape_xor_mask    <= RST_ESC_MASK;
      cfg_r.address_byte       <= RST_ADDRESS;
      cfg_r.control_frame_zero <= RST_CTRL_ZERO;
      cfg_r.control_frame_one  <= RST_CTRL_ONE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> rtl/core/hfr_rx_core.sv
// Frame phase tracking, destuffing and check logic of the HDLC-like frame receiver.
module hfr_rx_core
  import hfr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [BYTE_W-1:0] rx_byte,
  input  logic              frame_number,
  input  hfr_cfg_t          cfg,
  output hfr_result_t       result
);

  logic [PHASE_W-1:0] phase_r,   phase_nxt;
  logic [COUNT_W-1:0] count_r,   count_nxt;
  logic [BYTE_W-1:0]  xor_r,     xor_nxt;
  logic               escape_r,  escape_nxt;

  logic [BYTE_W-1:0]  ctrl_exp;
  logic [BYTE_W-1:0]  ctrl_other;
  logic [BYTE_W-1:0]  destuffed;
  logic               is_flag;

  assign ctrl_exp   = frame_number ? cfg.control_frame_one : cfg.control_frame_zero;
  assign ctrl_other = frame_number ? cfg.control_frame_zero : cfg.control_frame_one;
  assign destuffed  = escape_r ? (rx_byte ^ cfg.escape_xor_mask) : rx_byte;
  assign is_flag    = (rx_byte == cfg.flag_byte);

  // Next state and result for the current byte.
  always_comb begin
    phase_nxt  = phase_r;
    count_nxt  = count_r;
    xor_nxt    = xor_r;
    escape_nxt = escape_r;
    result     = '0;
    result.status = ST_BUSY;

    case (phase_r)
      PH_START: begin
        if (is_flag) begin
          phase_nxt = PH_ADDRESS;
        end
      end
      PH_ADDRESS: begin
        // An address equal to the flag counts as an address match.
        if (rx_byte == cfg.address_byte) begin
          phase_nxt = PH_CONTROL;
        end else if (is_flag) begin
          phase_nxt = PH_ADDRESS;
        end else begin
          phase_nxt     = PH_START;
          result.status = ST_BAD_ADDRESS;
        end
      end
      PH_CONTROL: begin
        if (rx_byte == ctrl_exp) begin
          phase_nxt = PH_BCC1;
        end else if (is_flag) begin
          phase_nxt = PH_ADDRESS;
        end else if (rx_byte == ctrl_other) begin
          // A repeat of the previous frame restarts without a report.
          phase_nxt = PH_START;
        end else begin
          phase_nxt     = PH_START;
          result.status = ST_BAD_CONTROL;
        end
      end
      PH_BCC1: begin
        if (rx_byte == (cfg.address_byte ^ ctrl_exp)) begin
          phase_nxt = PH_DATA;
        end else begin
          phase_nxt = PH_START;
        end
      end
      PH_DATA: begin
        if (is_flag) begin
          // Closing flag: the XOR over payload and BCC2 must be zero.
          if ((count_r != '0) && (xor_r == '0)) begin
            result.status       = ST_OK;
            result.frame_length = count_r - COUNT_W'(1);
          end else begin
            result.status = ST_BCC2_ERROR;
          end
          phase_nxt  = PH_START;
          count_nxt  = '0;
          xor_nxt    = '0;
          escape_nxt = 1'b0;
        end else if (count_r >= COUNT_LIMIT) begin
          result.status = ST_OVERFLOW;
          phase_nxt     = PH_START;
          count_nxt     = '0;
          xor_nxt       = '0;
          escape_nxt    = 1'b0;
        end else if (rx_byte == cfg.escape_byte) begin
          escape_nxt = 1'b1;
        end else begin
          escape_nxt        = 1'b0;
          xor_nxt           = xor_r ^ destuffed;
          result.data_valid = 1'b1;
          result.data_byte  = destuffed;
          result.data_index = count_r;
          count_nxt         = count_r + COUNT_W'(1);
        end
      end
      default: begin
        phase_nxt  = PH_START;
        count_nxt  = '0;
        xor_nxt    = '0;
        escape_nxt = 1'b0;
      end
    endcase
  end

  // Frame state advances once per processed byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_START;
      count_r  <= '0;
      xor_r    <= '0;
      escape_r <= 1'b0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      count_r  <= count_nxt;
      xor_r    <= xor_nxt;
      escape_r <= escape_nxt;
    end
  end

endmodule

>>> rtl/core/hdlc_like_frame_receiver.sv
// Top level of the HDLC-like byte-stuffed frame receiver.
//
// Raw line bytes enter on the in_ stream, one per transaction, with the
// expected frame number on in_tuser. Every accepted byte produces exactly one
// result transaction on the out_ stream: a status code, and for payload bytes
// the destuffed byte with its index; a good closing flag reports the payload
// length without BCC2.
// Registers are written through the cfg_ channel, which is always ready; they
// should only change while no byte is in flight.
// An accepted byte is held in the input register, processed combinationally
// and its result captured in the output register, which drives out_tvalid.
// Throughput is one byte per cycle while the downstream side does not stall,
// set by the phase/XOR/count update between the input and output registers.
// When the downstream side stalls, the output register holds its result and
// the input register holds the next byte; in_tready then drops until
// out_tready returns.
// Reset returns the receiver to the start phase, clears the byte count, the
// XOR and the escape flag, empties both registers and restores the register
// defaults.
module hdlc_like_frame_receiver
  import hfr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // Input stream.
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] rx_byte
  input  logic [0:0]            in_tuser,   // [0] frame_number
  // Result stream.
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [2:0] status, [3] data_valid,
                                            // [11:4] data_byte, [22:12] data_index,
                                            // [33:23] frame_length, [39:34] zero
  // Configuration write channel.
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [7:0]            cfg_data
);

  hfr_cfg_t    cfg;
  hfr_result_t result;

  logic              in_valid_r;
  logic [BYTE_W-1:0] in_byte_r;
  logic              in_fn_r;
  logic              out_valid_r;
  hfr_result_t       out_data_r;

  logic              out_free;
  logic              step;

  assign cfg_ready = 1'b1;

  hfr_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Handshake flow: the output register frees up when empty or being drained.
  assign out_free  = !out_valid_r || out_tready;
  assign step      = in_valid_r && out_free;
  assign in_tready = !in_valid_r || out_free;

  hfr_rx_core u_rx_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .rx_byte      (in_byte_r),
    .frame_number (in_fn_r),
    .cfg          (cfg),
    .result       (result)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
      in_fn_r   <= in_tuser[0];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - $bits(hfr_result_t)){1'b0}}, out_data_r};

  // A data byte is only ever reported while the frame is still in progress.
  a_data_busy : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.data_valid |-> out_data_r.status == ST_BUSY)
    else $error("data byte reported with a final status");

  // A length is only reported with a good frame.
  a_len_ok : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.status != ST_OK |-> out_data_r.frame_length == '0)
    else $error("frame length reported without a good frame");

  // The input side only stalls behind a held result.
  a_stall_cause : assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> in_valid_r && out_valid_r && !out_tready)
    else $error("input stalled without a downstream stall");

  // Data indexes stay below the overflow limit.
  a_index_range : assert property (@(posedge clk) disable iff (!rst_n)
    step && result.data_valid |-> result.data_index < COUNT_LIMIT)
    else $error("data index beyond payload limit");

endmodule

>>> dv/tb_hdlc_like_frame_receiver.sv
`timescale 1ns / 1ps
// Self-checking testbench of the HDLC-like frame receiver with its own byte-level predictor.
module tb_hdlc_like_frame_receiver;
  import hfr_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned PHASE_COUNT   = 8;
  localparam int unsigned PHASE_ITEMS   = 70;
  localparam int unsigned DIRECTED_ROWS = 30;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata   = '0;   // [7:0] rx_byte
  logic [0:0]            in_tuser   = '0;   // [0] frame_number
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;         // [2:0] status, [3] data_valid,
                                            // [11:4] data_byte, [22:12] data_index,
                                            // [33:23] frame_length, [39:34] zero
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = REG_FLAG;
  logic [7:0]            cfg_data   = '0;

  // Predictor state: register settings and the frame being received.
  hfr_cfg_t           line_cfg;
  logic [PHASE_W-1:0] line_phase;
  logic [COUNT_W-1:0] line_count;
  logic [7:0]         line_xor;
  logic               line_escaped;

  // Reports predicted for accepted bytes, oldest first.
  hfr_result_t pending_rx_reports [$];

  int unsigned error_count     = 0;
  int unsigned items_sent      = 0;
  int unsigned reports_seen    = 0;
  int unsigned settings_loaded = 1;
  int unsigned status_tally [8];
  int unsigned send_idle_pct   = 0;
  int unsigned recv_stall_pct  = 0;
  int unsigned hold_requests   = 0;
  int unsigned hold_served     = 0;
  int unsigned hold_left       = 0;
  int unsigned cycles_run      = 0;

  // Directed rows; a typed-in status and length replace the prediction where set.
  typedef struct {
    logic [7:0]          rx_byte;
    logic                frame_number;
    bit                  typed;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  frame_length;
  } line_row_t;

  line_row_t directed_rows [DIRECTED_ROWS] = '{
    '{8'h7E, 1'b0, 1'b0, ST_BUSY,        11'd0},  // opening flag
    '{8'h7E, 1'b0, 1'b0, ST_BUSY,        11'd0},  // repeated flag in address phase
    '{8'hFF, 1'b1, 1'b1, ST_BAD_ADDRESS, 11'd0},
    '{8'h7E, 1'b1, 1'b0, ST_BUSY,        11'd0},
    '{8'h03, 1'b1, 1'b0, ST_BUSY,        11'd0},
    '{8'h7E, 1'b1, 1'b0, ST_BUSY,        11'd0},  // repeated flag in control phase
    '{8'h03, 1'b1, 1'b0, ST_BUSY,        11'd0},
    '{8'h00, 1'b1, 1'b1, ST_BUSY,        11'd0},  // control of the other frame
    '{8'h7E, 1'b0, 1'b0, ST_BUSY,        11'd0},
    '{8'h03, 1'b0, 1'b0, ST_BUSY,        11'd0},
    '{8'h11, 1'b0, 1'b1, ST_BAD_CONTROL, 11'd0},
    '{8'h7E, 1'b0, 1'b0, ST_BUSY,        11'd0},
    '{8'h03, 1'b0, 1'b0, ST_BUSY,        11'd0},
    '{8'h00, 1'b0, 1'b0, ST_BUSY,        11'd0},
    '{8'h55, 1'b0, 1'b1, ST_BUSY,        11'd0},  // bad BCC1 restarts quietly
    '{8'h7E, 1'b0, 1'b0, ST_BUSY,        11'd0},
    '{8'h03, 1'b0, 1'b0, ST_BUSY,        11'd0},
    '{8'h00, 1'b0, 1'b0, ST_BUSY,        11'd0},
    '{8'h03, 1'b0, 1'b0, ST_BUSY,        11'd0},
    '{8'h7E, 1'b0, 1'b1, ST_BCC2_ERROR,  11'd0},  // empty frame
    '{8'h7E, 1'b1, 1'b0, ST_BUSY,        11'd0},
    '{8'h03, 1'b1, 1'b0, ST_BUSY,        11'd0},
    '{8'h40, 1'b1, 1'b0, ST_BUSY,        11'd0},
    '{8'h43, 1'b1, 1'b0, ST_BUSY,        11'd0},
    '{8'hFF, 1'b1, 1'b0, ST_BUSY,        11'd0},
    '{8'h7D, 1'b1, 1'b1, ST_BUSY,        11'd0},  // escape
    '{8'h7D, 1'b1, 1'b1, ST_BUSY,        11'd0},  // escape after escape
    '{8'h5E, 1'b1, 1'b0, ST_BUSY,        11'd0},
    '{8'h81, 1'b1, 1'b0, ST_BUSY,        11'd0},  // BCC2
    '{8'h7E, 1'b1, 1'b1, ST_OK,          11'd2}
  };

  hdlc_like_frame_receiver u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // 100 MHz clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Abandon the current frame and wait for the next opening flag.
  function automatic void drop_frame();
    line_phase   = PH_START;
    line_count   = '0;
    line_xor     = '0;
    line_escaped = 1'b0;
  endfunction

  // Advance the predicted receiver by one line byte and return its report.
  function automatic hfr_result_t receive_line_byte(logic [7:0] b, logic fn);
    hfr_result_t rep;
    logic [7:0]  ctrl_this;
    logic [7:0]  ctrl_other;
    logic [7:0]  d;
    rep        = '0;
    ctrl_this  = fn ? line_cfg.control_frame_one : line_cfg.control_frame_zero;
    ctrl_other = fn ? line_cfg.control_frame_zero : line_cfg.control_frame_one;
    case (line_phase)
      PH_START: begin
        if (b == line_cfg.flag_byte) line_phase = PH_ADDRESS;
      end
      PH_ADDRESS: begin
        // The address match wins over a flag of the same value.
        if (b == line_cfg.address_byte) begin
          line_phase = PH_CONTROL;
        end else if (b != line_cfg.flag_byte) begin
          line_phase = PH_START;
          rep.status = ST_BAD_ADDRESS;
        end
      end
      PH_CONTROL: begin
        if (b == ctrl_this) begin
          line_phase = PH_BCC1;
        end else if (b == line_cfg.flag_byte) begin
          line_phase = PH_ADDRESS;
        end else begin
          // The other frame's control byte restarts without a report.
          line_phase = PH_START;
          if (b != ctrl_other) rep.status = ST_BAD_CONTROL;
        end
      end
      PH_BCC1: begin
        line_phase = (b == (line_cfg.address_byte ^ ctrl_this)) ? PH_DATA : PH_START;
      end
      PH_DATA: begin
        if (b == line_cfg.flag_byte) begin
          if (line_count != 0 && line_xor == 0) begin
            rep.status       = ST_OK;
            rep.frame_length = line_count - 1'b1;
          end else begin
            rep.status = ST_BCC2_ERROR;
          end
          drop_frame();
        end else if (line_count >= COUNT_LIMIT) begin
          rep.status = ST_OVERFLOW;
          drop_frame();
        end else if (b == line_cfg.escape_byte) begin
          line_escaped = 1'b1;
        end else begin
          d               = line_escaped ? (b ^ line_cfg.escape_xor_mask) : b;
          line_escaped    = 1'b0;
          line_xor        = line_xor ^ d;
          rep.data_valid  = 1'b1;
          rep.data_byte   = d;
          rep.data_index  = line_count;
          line_count      = line_count + 1'b1;
        end
      end
      default: drop_frame();
    endcase
    return rep;
  endfunction

  // Offer one line byte, with random idle cycles first, and record its prediction.
  task automatic send_byte(logic [7:0] b, logic fn);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= fn;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_rx_reports.push_back(receive_line_byte(b, fn));
    items_sent++;
  endtask

  // Send a payload byte, escaping it when it collides with the flag or escape.
  task automatic send_stuffed(logic [7:0] d);
    if (d == line_cfg.flag_byte || d == line_cfg.escape_byte) begin
      send_byte(line_cfg.escape_byte, 1'($urandom_range(0, 1)));
      send_byte(d ^ line_cfg.escape_xor_mask, 1'($urandom_range(0, 1)));
    end else begin
      send_byte(d, 1'($urandom_range(0, 1)));
    end
  endtask

  // Send one frame; unless clean, a random flavor breaks one part of it.
  task automatic send_frame(int unsigned payload_len, bit clean);
    int unsigned flavor;
    logic        fn;
    logic [7:0]  ctrl;
    logic [7:0]  d;
    logic [7:0]  bcc2;
    flavor = clean ? 100 : $urandom_range(0, 99);
    fn     = 1'($urandom_range(0, 1));
    ctrl   = fn ? line_cfg.control_frame_one : line_cfg.control_frame_zero;
    bcc2   = '0;
    // Line noise ahead of the opening flag.
    if (flavor < 8) begin
      repeat ($urandom_range(1, 4)) send_byte(8'($urandom), 1'($urandom_range(0, 1)));
    end
    send_byte(line_cfg.flag_byte, fn);
    if (flavor >= 8 && flavor < 12) send_byte(line_cfg.flag_byte, fn);
    send_byte((flavor >= 12 && flavor < 17) ? 8'($urandom) : line_cfg.address_byte, fn);
    if (flavor >= 17 && flavor < 20) begin
      send_byte(fn ? line_cfg.control_frame_zero : line_cfg.control_frame_one, fn);
    end else if (flavor >= 20 && flavor < 23) begin
      send_byte(8'($urandom), fn);
    end else begin
      send_byte(ctrl, fn);
    end
    send_byte((flavor >= 23 && flavor < 27) ? 8'($urandom)
                                            : (line_cfg.address_byte ^ ctrl), fn);
    // Payload, biased toward bytes that need stuffing.
    for (int unsigned i = 0; i < payload_len; i++) begin
      case ($urandom_range(0, 7))
        0:       d = line_cfg.flag_byte;
        1:       d = line_cfg.escape_byte;
        default: d = 8'($urandom);
      endcase
      bcc2 = bcc2 ^ d;
      send_stuffed(d);
    end
    if (flavor >= 27 && flavor < 35) bcc2 = bcc2 ^ 8'($urandom_range(1, 255));
    if (flavor < 35 || flavor >= 39) send_stuffed(bcc2);
    if (flavor >= 39 && flavor < 44) send_byte(line_cfg.escape_byte, fn);
    send_byte(line_cfg.flag_byte, fn);
  endtask

  // Write one register and mirror it in the predictor.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_FLAG:      line_cfg.flag_byte          = value;
      REG_ESCAPE:    line_cfg.escape_byte        = value;
      REG_ESC_MASK:  line_cfg.escape_xor_mask    = value;
      REG_ADDRESS:   line_cfg.address_byte       = value;
      REG_CTRL_ZERO: line_cfg.control_frame_zero = value;
      REG_CTRL_ONE:  line_cfg.control_frame_one  = value;
      default: ;
    endcase
  endtask

  task automatic load_settings(hfr_cfg_t s);
    write_reg(REG_FLAG,      s.flag_byte);
    write_reg(REG_ESCAPE,    s.escape_byte);
    write_reg(REG_ESC_MASK,  s.escape_xor_mask);
    write_reg(REG_ADDRESS,   s.address_byte);
    write_reg(REG_CTRL_ZERO, s.control_frame_zero);
    write_reg(REG_CTRL_ONE,  s.control_frame_one);
    cfg_valid <= 1'b0;
    settings_loaded++;
  endtask

  // Stop offering bytes and let every predicted report come back.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_rx_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Result side: random stalls, plus a long hold-off whenever one is requested.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left = hold_left - 1;
    end else if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left   = HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Compare every result transaction with the oldest prediction.
  always @(posedge clk) begin
    hfr_result_t got;
    hfr_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[$bits(hfr_result_t)-1:0];
      reports_seen++;
      if (pending_rx_reports.size() == 0) begin
        $error("Result %h arrived with no byte outstanding", got);
        error_count++;
      end else begin
        want = pending_rx_reports.pop_front();
        status_tally[got.status]++;
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          error_count++;
        end
        if (got.data_valid !== want.data_valid) begin
          $error("data_valid: expected %0d, got %0d", want.data_valid, got.data_valid);
          error_count++;
        end
        if (got.data_byte !== want.data_byte) begin
          $error("data_byte: expected %h, got %h", want.data_byte, got.data_byte);
          error_count++;
        end
        if (got.data_index !== want.data_index) begin
          $error("data_index: expected %0d, got %0d", want.data_index, got.data_index);
          error_count++;
        end
        if (got.frame_length !== want.frame_length) begin
          $error("frame_length: expected %0d, got %0d", want.frame_length,
                 got.frame_length);
          error_count++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles_run++;
    if (cycles_run > CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d reports outstanding.", cycles_run,
               pending_rx_reports.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Stimulus: directed rows, then random frames over several settings and idle patterns.
  initial begin
    hfr_cfg_t    settings;
    hfr_result_t typed_result;
    int unsigned phase_start;
    line_cfg = {RST_FLAG, RST_ESCAPE, RST_ESC_MASK, RST_ADDRESS, RST_CTRL_ZERO, RST_CTRL_ONE};
    drop_frame();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    for (int unsigned phase = 0; phase < PHASE_COUNT; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
        default: begin send_idle_pct = 19; recv_stall_pct = 19; end
      endcase

      if (phase == 0) begin
        foreach (directed_rows[r]) begin
          send_byte(directed_rows[r].rx_byte, directed_rows[r].frame_number);
          if (directed_rows[r].typed) begin
            typed_result              = '0;
            typed_result.status       = directed_rows[r].status;
            typed_result.frame_length = directed_rows[r].frame_length;
            pending_rx_reports[pending_rx_reports.size()-1] = typed_result;
          end
        end
        // Long hold-off on the result side while a frame one byte past the payload
        // limit streams in and overflows.
        hold_requests++;
        send_frame(MAX_PAYLOAD + 1, 1'b1);
      end else begin
        case (phase)
          1: settings = {8'h00, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'h00};
          2: settings = {8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'hFF};
          default: begin
            settings = 48'({$urandom, $urandom});
            if (settings.escape_byte == settings.flag_byte)
              settings.escape_byte = ~settings.flag_byte;
          end
        endcase
        wait_idle();
        load_settings(settings);
      end

      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        send_frame(($urandom_range(0, 9) == 0) ? $urandom_range(13, 60)
                                               : $urandom_range(0, 12), 1'b0);
      end
    end

    wait_idle();
    $display("Run covered %0d line bytes and %0d reports under %0d register settings.",
             items_sent, reports_seen, settings_loaded);
    $display("Reports: %0d good frames, %0d bad address, %0d bad control, %0d BCC2, %0d overflow.",
             status_tally[ST_OK], status_tally[ST_BAD_ADDRESS], status_tally[ST_BAD_CONTROL],
             status_tally[ST_BCC2_ERROR], status_tally[ST_OVERFLOW]);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
